@@ hdl/dpbn_pkg.sv @@
package dpbn_pkg;

  // Default values for the top-level parameters.
  localparam int SUM_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int ACT_W   = 16;
  localparam int MEAN_W  = 48;
  localparam int VAR_W   = 32;
  localparam int GAMMA_W = 32;
  localparam int BETA_W  = 48;
  localparam int OUT_W   = 64;

  // Row queue between the accumulator and the normalisation engine.
  localparam int QUEUE_DEPTH = 2;

  // Magnitude product |gamma| * |d| and the number of restoring division steps.
  localparam int PROD_W    = GAMMA_W + OUT_W;
  localparam int DIV_STEPS = PROD_W;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // One finished row: the saturated sum and the row's normalisation operands.
  typedef struct packed {
    logic signed [OUT_W-1:0]   sum;
    logic signed [MEAN_W-1:0]  mean;
    logic        [VAR_W-1:0]   variance;
    logic signed [GAMMA_W-1:0] gamma;
    logic signed [BETA_W-1:0]  beta;
    logic                      norm_en;
  } row_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_NORM,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } back_state_e;

endpackage

@@ hdl/dpbn_front.sv @@
module dpbn_front #(
  parameter int SUM_WIDTH = dpbn_pkg::SUM_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [dpbn_pkg::ACT_W-1:0]     activation_i,
  input  logic signed [dpbn_pkg::ACT_W-1:0]     weight_i,
  input  logic                                  last_of_row_i,
  input  logic signed [dpbn_pkg::MEAN_W-1:0]    norm_mean_i,
  input  logic        [dpbn_pkg::VAR_W-1:0]     norm_variance_i,
  input  logic signed [dpbn_pkg::GAMMA_W-1:0]   norm_gamma_i,
  input  logic signed [dpbn_pkg::BETA_W-1:0]    norm_beta_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output dpbn_pkg::row_job_t                    job_o
);

  logic                        norm_en_q;
  logic signed [SUM_WIDTH-1:0] acc_q, acc_d;
  logic signed [2*dpbn_pkg::ACT_W-1:0] prod;
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic                        accept;

  assign prod    = activation_i * weight_i;
  assign sum_ext = (SUM_WIDTH+1)'(acc_q) + (SUM_WIDTH+1)'(prod);

  // The top two bits differ only when the sum left the accumulator's range.
  always_comb begin
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_sat = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                   : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_WIDTH-1:0];
    end
  end

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && last_of_row_i;

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = last_of_row_i ? '0 : sum_sat;
    end
  end

  always_comb begin
    job_o.sum      = dpbn_pkg::OUT_W'(sum_sat);
    job_o.mean     = norm_mean_i;
    job_o.variance = norm_variance_i;
    job_o.gamma    = norm_gamma_i;
    job_o.beta     = norm_beta_i;
    job_o.norm_en  = norm_en_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      norm_en_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (cfg_we_i) begin
        norm_en_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ hdl/dpbn_fifo.sv @@
module dpbn_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dpbn_pkg::row_job_t data_i,
  input  logic               pop_i,
  output dpbn_pkg::row_job_t data_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int Depth = dpbn_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

  dpbn_pkg::row_job_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i)
    else $error("row queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("row queue read while empty");
`endif

endmodule

@@ hdl/dpbn_back.sv @@
module dpbn_back #(
  parameter int FRAC_BITS = dpbn_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  dpbn_pkg::row_job_t                  job_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dpbn_pkg::OUT_W-1:0]   neuron_value_o,
  output logic                                divide_error_o
);

  localparam int OW  = dpbn_pkg::OUT_W;
  localparam int GW  = dpbn_pkg::GAMMA_W;
  localparam int VW  = dpbn_pkg::VAR_W;
  localparam int PW  = dpbn_pkg::PROD_W;
  localparam int CW  = $clog2(dpbn_pkg::DIV_STEPS);
  localparam int SHW = 2*OW;

  dpbn_pkg::back_state_e state_q, state_d;
  dpbn_pkg::row_job_t    job_q;

  logic signed [OW-1:0] x_q, value_q;
  logic                 err_q, neg_q;
  logic [GW-1:0]        ga_q;
  logic [OW-1:0]        da_q, plo_q;
  logic [PW-1:0]        num_q;
  logic [VW-1:0]        rem_q;
  logic [CW-1:0]        cnt_q;
  logic                 div_last;

  // Sum scaled to Q.FRAC_BITS and saturated to the output width.
  logic signed [SHW-1:0] shifted;
  logic signed [OW-1:0]  x_sat;
  assign shifted = SHW'(job_q.sum) <<< FRAC_BITS;
  always_comb begin
    if (shifted[SHW-1:OW-1] != {(SHW-OW+1){shifted[SHW-1]}}) begin
      x_sat = shifted[SHW-1] ? dpbn_pkg::OUT_MIN : dpbn_pkg::OUT_MAX;
    end else begin
      x_sat = shifted[OW-1:0];
    end
  end

  // Centred value d = x - mean, saturated.
  logic signed [OW:0]   d_ext;
  logic signed [OW-1:0] d_sat;
  logic                 d_neg, g_neg, zero_var_min;
  assign d_ext = (OW+1)'(x_q) - (OW+1)'(job_q.mean);
  always_comb begin
    if (d_ext[OW] != d_ext[OW-1]) begin
      d_sat = d_ext[OW] ? dpbn_pkg::OUT_MIN : dpbn_pkg::OUT_MAX;
    end else begin
      d_sat = d_ext[OW-1:0];
    end
  end
  assign d_neg = d_sat[OW-1];
  assign g_neg = job_q.gamma[GW-1];
  assign zero_var_min = (d_neg != g_neg) && (d_sat != '0) && (job_q.gamma != '0);

  // Upper partial product of |gamma| * |d|, kept at its full width.
  logic [2*GW-1:0] phi;
  assign phi = ga_q * da_q[OW-1:OW/2];

  // One restoring division step.
  logic [VW:0] trial;
  logic        q_bit;
  logic [VW:0] trial_diff;
  assign trial      = {rem_q, num_q[PW-1]};
  assign trial_diff = trial - {1'b0, job_q.variance};
  assign q_bit      = (trial >= {1'b0, job_q.variance});

  // Signed quotient, saturated, plus beta.
  logic                 q_ovf;
  logic signed [OW-1:0] q_val;
  logic signed [OW:0]   r_ext;
  logic signed [OW-1:0] r_sat;
  assign q_ovf = |num_q[PW-1:OW-1];
  always_comb begin
    if (q_ovf) begin
      q_val = neg_q ? dpbn_pkg::OUT_MIN : dpbn_pkg::OUT_MAX;
    end else if (neg_q) begin
      q_val = -$signed(num_q[OW-1:0]);
    end else begin
      q_val = $signed(num_q[OW-1:0]);
    end
  end
  assign r_ext = (OW+1)'(q_val) + (OW+1)'(job_q.beta);
  always_comb begin
    if (r_ext[OW] != r_ext[OW-1]) begin
      r_sat = r_ext[OW] ? dpbn_pkg::OUT_MIN : dpbn_pkg::OUT_MAX;
    end else begin
      r_sat = r_ext[OW-1:0];
    end
  end

  assign div_last = (cnt_q == CW'(dpbn_pkg::DIV_STEPS-1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      dpbn_pkg::BK_IDLE:   if (!empty_i) state_d = dpbn_pkg::BK_PREP;
      dpbn_pkg::BK_PREP:   state_d = job_q.norm_en ? dpbn_pkg::BK_NORM : dpbn_pkg::BK_OUT;
      dpbn_pkg::BK_NORM:   state_d = (job_q.variance == '0) ? dpbn_pkg::BK_OUT
                                                            : dpbn_pkg::BK_MUL_LO;
      dpbn_pkg::BK_MUL_LO: state_d = dpbn_pkg::BK_MUL_HI;
      dpbn_pkg::BK_MUL_HI: state_d = dpbn_pkg::BK_DIV;
      dpbn_pkg::BK_DIV:    if (div_last) state_d = dpbn_pkg::BK_FIN;
      dpbn_pkg::BK_FIN:    state_d = dpbn_pkg::BK_OUT;
      dpbn_pkg::BK_OUT:    if (!out_stall_i) state_d = dpbn_pkg::BK_IDLE;
      default:             state_d = dpbn_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      dpbn_pkg::BK_IDLE: pop_o       = !empty_i;
      dpbn_pkg::BK_OUT:  out_valid_o = 1'b1;
      default: begin
        pop_o       = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign neuron_value_o = value_q;
  assign divide_error_o = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpbn_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dpbn_pkg::BK_IDLE: begin
        job_q <= job_i;
      end
      dpbn_pkg::BK_PREP: begin
        x_q     <= x_sat;
        value_q <= x_sat;
        err_q   <= 1'b0;
      end
      dpbn_pkg::BK_NORM: begin
        neg_q   <= (d_neg != g_neg);
        da_q    <= d_neg ? -d_sat : d_sat;
        ga_q    <= g_neg ? -job_q.gamma : job_q.gamma;
        err_q   <= (job_q.variance == '0);
        value_q <= zero_var_min ? dpbn_pkg::OUT_MIN : dpbn_pkg::OUT_MAX;
      end
      dpbn_pkg::BK_MUL_LO: begin
        plo_q <= ga_q * da_q[OW/2-1:0];
      end
      dpbn_pkg::BK_MUL_HI: begin
        num_q <= PW'(plo_q) + (PW'(phi) << (OW/2));
        rem_q <= '0;
        cnt_q <= '0;
      end
      dpbn_pkg::BK_DIV: begin
        rem_q <= q_bit ? trial_diff[VW-1:0] : trial[VW-1:0];
        num_q <= {num_q[PW-2:0], q_bit};
        cnt_q <= cnt_q + 1'b1;
      end
      dpbn_pkg::BK_FIN: begin
        value_q <= r_sat;
      end
      default: begin
        value_q <= value_q;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dpbn_pkg::BK_DIV |=> state_q == dpbn_pkg::BK_DIV || state_q == dpbn_pkg::BK_FIN)
    else $error("division left before its last step");
`endif

endmodule

@@ hdl/int16_dot_product_batchnorm_unit.sv @@
// After its last transaction is accepted, a row goes through the queue and the back-end
// states PREP, NORM if normalising and, unless the variance is zero, MUL_LO, MUL_HI, the
// bit-serial divider and FIN, then OUT. Throughput: one element transaction per cycle
// while the queue is not full; the back end takes one row at a time, and a two-row queue
// decouples it from the front. Reset (rst_ni, asynchronous, active low) clears the
// running sum, the enable register, the row queue and the back-end state machine.
module int16_dot_product_batchnorm_unit #(
  parameter int SUM_WIDTH = dpbn_pkg::SUM_WIDTH_DEF,
  parameter int FRAC_BITS = dpbn_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [dpbn_pkg::ACT_W-1:0]     activation_i,
  input  logic signed [dpbn_pkg::ACT_W-1:0]     weight_i,
  input  logic                                  last_of_row_i,
  input  logic signed [dpbn_pkg::MEAN_W-1:0]    norm_mean_i,
  input  logic        [dpbn_pkg::VAR_W-1:0]     norm_variance_i,
  input  logic signed [dpbn_pkg::GAMMA_W-1:0]   norm_gamma_i,
  input  logic signed [dpbn_pkg::BETA_W-1:0]    norm_beta_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [dpbn_pkg::OUT_W-1:0]     neuron_value_o,
  output logic                                  divide_error_o
);

  // The front end multiplies and accumulates one element per cycle while the queue is not
  // full. On the last element of a row it pushes the saturated sum together with the row's
  // normalisation operands into the queue and clears the running sum.
  dpbn_pkg::row_job_t push_job, pop_job;
  logic push, pop, full, empty;

  dpbn_front #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .activation_i    (activation_i),
    .weight_i        (weight_i),
    .last_of_row_i   (last_of_row_i),
    .norm_mean_i     (norm_mean_i),
    .norm_variance_i (norm_variance_i),
    .norm_gamma_i    (norm_gamma_i),
    .norm_beta_i     (norm_beta_i),
    .full_i          (full),
    .push_o          (push),
    .job_o           (push_job)
  );

  // The queue lets the front carry on with the next row while the back end is still
  // dividing, or while a result waits to be taken.
  dpbn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (pop_job),
    .full_o  (full),
    .empty_o (empty)
  );

  // The back end scales the sum, applies gamma*(sum-mean)/variance+beta when normalising
  // via a split 32-bit multiplier and a restoring divider, and holds the result register.
  dpbn_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .job_i          (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .neuron_value_o (neuron_value_o),
    .divide_error_o (divide_error_o)
  );

`ifndef ASSERT_OFF
  a_err_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |->
      neuron_value_o == dpbn_pkg::OUT_MAX || neuron_value_o == dpbn_pkg::OUT_MIN)
    else $error("divide error with an unsaturated result");
`endif

endmodule

@@ test/tb_int16_dot_product_batchnorm_unit.sv @@
module tb_int16_dot_product_batchnorm_unit;

  localparam int SUM_W = dpbn_pkg::SUM_WIDTH_DEF;
  localparam int FRAC = dpbn_pkg::FRAC_BITS_DEF;
  localparam int ACT_W = dpbn_pkg::ACT_W;
  localparam int MEAN_W = dpbn_pkg::MEAN_W;
  localparam int VAR_W = dpbn_pkg::VAR_W;
  localparam int GAMMA_W = dpbn_pkg::GAMMA_W;
  localparam int BETA_W = dpbn_pkg::BETA_W;
  localparam int OUT_W = dpbn_pkg::OUT_W;
  // Limits of the signed running sum.
  localparam logic signed [63:0] SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam logic signed [63:0] SUM_MIN = -(64'sd1 <<< (SUM_W - 1));
  // Cycles to let pass once the last row result is in, before touching the register.
  localparam int DRAIN_CYCLES = 160;

  // One element transaction as offered to the block.
  typedef struct {
    logic signed [ACT_W-1:0]   act;
    logic signed [ACT_W-1:0]   wgt;
    logic                      last;
    logic signed [MEAN_W-1:0]  mean;
    logic        [VAR_W-1:0]   variance;
    logic signed [GAMMA_W-1:0] gamma;
    logic signed [BETA_W-1:0]  beta;
  } element_t;

  // One row result as the block should deliver it.
  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    err;
  } neuron_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [ACT_W-1:0] activation_i = '0;
  logic signed [ACT_W-1:0] weight_i = '0;
  logic last_of_row_i = 1'b0;
  logic signed [MEAN_W-1:0] norm_mean_i = '0;
  logic [VAR_W-1:0] norm_variance_i = '0;
  logic signed [GAMMA_W-1:0] norm_gamma_i = '0;
  logic signed [BETA_W-1:0] norm_beta_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] neuron_value_o;
  logic divide_error_o;

  // Elements waiting to be offered, and row results waiting to arrive.
  element_t element_q[$];
  neuron_t  neuron_q[$];
  element_t offered;

  // The predictor's own copy of the enable register and of the running sum.
  logic norm_on = 1'b0;
  logic signed [63:0] row_sum = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;
  int mismatches = 0;

  int16_dot_product_batchnorm_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .activation_i   (activation_i),
    .weight_i       (weight_i),
    .last_of_row_i  (last_of_row_i),
    .norm_mean_i    (norm_mean_i),
    .norm_variance_i(norm_variance_i),
    .norm_gamma_i   (norm_gamma_i),
    .norm_beta_i    (norm_beta_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .neuron_value_o (neuron_value_o),
    .divide_error_o (divide_error_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Clamps a 65-bit intermediate to the signed 64-bit range.
  function automatic logic signed [63:0] clamp64(logic signed [64:0] v);
    if (v[64] != v[63]) return v[64] ? dpbn_pkg::OUT_MIN : dpbn_pkg::OUT_MAX;
    return v[63:0];
  endfunction

  // Adds one accepted element to the running sum. On the last element of a row
  // it works out the neuron value, raw or batch-normalised, and queues it.
  function automatic void accumulate_element(element_t e);
    logic signed [63:0] s, x, d, q;
    logic signed [64:0] t, g65;
    logic [63:0] gmag, dmag;
    logic [127:0] prod, quo;
    logic neg;
    neuron_t n;
    s = row_sum + 64'(e.act) * 64'(e.wgt);
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    if (!e.last) begin
      row_sum = s;
      return;
    end
    row_sum = '0;
    // A sum of SUM_W bits shifted by FRAC bits always fits in 64 bits.
    x = s <<< FRAC;
    n.value = x;
    n.err = 1'b0;
    if (norm_on) begin
      t = 65'(x);
      t = t - e.mean;
      d = clamp64(t);
      neg = (e.gamma < 0) != (d < 0);
      if (e.variance == '0) begin
        // Division by zero: flag it and saturate by the sign of gamma * d.
        n.err = 1'b1;
        n.value = (e.gamma == 0 || d == 0 || !neg) ? dpbn_pkg::OUT_MAX : dpbn_pkg::OUT_MIN;
      end else begin
        g65 = 65'(e.gamma);
        gmag = (g65 < 0) ? 64'(-g65) : 64'(g65);
        t = 65'(d);
        dmag = (t < 0) ? 64'(-t) : 64'(t);
        prod = 128'(gmag) * 128'(dmag);
        quo = prod / 128'(e.variance);
        if (quo >= 128'h8000_0000_0000_0000) begin
          q = neg ? dpbn_pkg::OUT_MIN : dpbn_pkg::OUT_MAX;
        end else begin
          q = neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
        end
        t = 65'(q);
        t = t + e.beta;
        n.value = clamp64(t);
      end
    end
    neuron_q.push_back(n);
  endfunction

  // Driver: a new element is put up once the current one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) accumulate_element(offered);
      if (!in_valid_i || !in_stall_o) begin
        if (element_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered         <= element_q[0];
          activation_i    <= element_q[0].act;
          weight_i        <= element_q[0].wgt;
          last_of_row_i   <= element_q[0].last;
          norm_mean_i     <= element_q[0].mean;
          norm_variance_i <= element_q[0].variance;
          norm_gamma_i    <= element_q[0].gamma;
          norm_beta_i     <= element_q[0].beta;
          in_valid_i      <= 1'b1;
          void'(element_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    neuron_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (neuron_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d err %0b", neuron_value_o, divide_error_o);
      end else begin
        want = neuron_q.pop_front();
        if (want.value !== neuron_value_o || want.err !== divide_error_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d err %0b, got value %0d err %0b",
                     want.value, want.err, neuron_value_o, divide_error_o);
        end
      end
    end
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Long hold-off of the receiver, so that the row queue fills and the input stalls.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (700) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Random bits with the extremes of a field of width w weighted in.
  function automatic logic [63:0] pick_bits(int w);
    case ($urandom_range(7))
      0: return 64'd1 << (w - 1);
      1: return (64'd1 << (w - 1)) - 1;
      2: return '0;
      3: return '1;
      4: return 64'($urandom_range(16, 1));
      5: return -64'($urandom_range(4096));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic element_t make_element(logic last);
    element_t e;
    e.act = ACT_W'(pick_bits(ACT_W));
    e.wgt = ACT_W'(pick_bits(ACT_W));
    e.last = last;
    e.mean = MEAN_W'(pick_bits(MEAN_W));
    e.variance = VAR_W'(pick_bits(VAR_W));
    e.gamma = GAMMA_W'(pick_bits(GAMMA_W));
    e.beta = BETA_W'(pick_bits(BETA_W));
    return e;
  endfunction

  function automatic void push_row(int len);
    for (int i = 1; i <= len; i++) element_q.push_back(make_element(i == len));
  endfunction

  function automatic void push_pair(int a, int w, logic last);
    element_t e;
    e = make_element(last);
    e.act = ACT_W'(a);
    e.wgt = ACT_W'(w);
    element_q.push_back(e);
  endfunction

  function automatic void push_norm(int a, int w, logic signed [MEAN_W-1:0] m,
                                    logic [VAR_W-1:0] v, logic signed [GAMMA_W-1:0] g,
                                    logic signed [BETA_W-1:0] b);
    element_t e;
    e.act = ACT_W'(a);
    e.wgt = ACT_W'(w);
    e.last = 1'b1;
    e.mean = m;
    e.variance = v;
    e.gamma = g;
    e.beta = b;
    element_q.push_back(e);
  endfunction

  // Lets every queued element in and every predicted result out, then the back end settle.
  task automatic wait_idle();
    while (element_q.size() > 0 || in_valid_i || neuron_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_enable(logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    norm_on = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Raw path: extreme products, an empty product and a multi-element row.
    write_enable(1'b0);
    push_pair(32767, 32767, 1'b1);
    push_pair(-32768, -32768, 1'b1);
    push_pair(-32768, 32767, 1'b1);
    push_pair(0, 0, 1'b1);
    push_row(5);
    wait_idle();

    // Normalised path: zero variance with each sign, divider overflow, extreme operands.
    write_enable(1'b1);
    hold_go = 1'b1;
    push_norm(3, 4, 0, 0, 5, 0);
    push_norm(3, 4, 0, 0, -5, 0);
    push_norm(3, 4, 0, 0, 0, 0);
    push_norm(0, 0, 0, 0, -7, 0);
    push_norm(3, 4, 48'sd786432, 0, -1, 0);
    push_norm(100, 7, 48'sd65536, 32'h0001_0000, 32'sh0001_8000, -48'sd3);
    push_norm(-32768, 32767, 0, 1, 32'sh7FFF_FFFF, 0);
    push_norm(32767, 32767, 48'sh8000_0000_0000, 32'hFFFF_FFFF, 32'sh8000_0000, 0);
    push_norm(1, 1, 0, 32'h0001_0000, 32'sh0001_0000, 48'sh7FFF_FFFF_FFFF);
    push_norm(-1, 1, 0, 32'h0001_0000, 32'sh0001_0000, 48'sh8000_0000_0000);
    push_norm(-5, 3, 48'sh7FFF_FFFF_FFFF, 32'd7, 32'sd3, 48'sd11);
    push_row(4);
    push_row(40);
    wait_idle();

    // Random rows under each pattern of idling, the register flipping between phases.
    for (int ph = 0; ph < 6; ph++) begin
      write_enable(ph % 2 == 0);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      n = 0;
      while (n < 205) begin
        if ($urandom_range(9) == 0) begin
          push_row($urandom_range(24, 7));
          n += 16;
        end else begin
          push_row($urandom_range(4, 1));
          n += 2;
        end
      end
      // One lone single-element row to close each phase.
      push_row(1);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
